// ===== design/mck_pkg.sv =====
// mck_pkg: shared types, constants and the morse lookup table for the keyer
// used by mck_ctrl, mck_dpath and morse_char_keyer; depends on nothing

package mck_pkg;

   localparam int CharWidth  = 8;
   localparam int UnitWidth  = 12;
   localparam int DurWidth   = 15;
   localparam int MaxElems   = 6;
   localparam int CountWidth = 3;

   localparam logic [UnitWidth-1:0] UnitReset = 12'd250;

   localparam logic [CharWidth-1:0] CharSpace  = 8'h20;
   localparam logic [CharWidth-1:0] CharLowerA = 8'h61;
   localparam logic [CharWidth-1:0] CharLowerZ = 8'h7a;
   localparam logic [CharWidth-1:0] CaseOffset = 8'h20;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_ELEM_GAP,
      ST_END_GAP
   } state_type;

   // kind of segment the datapath should place in the output register
   typedef enum logic [1:0] {
      SEG_MARK,
      SEG_ELEM_GAP,
      SEG_END_GAP
   } seg_type;

   // looked-up code: dash bit i belongs to element i, element 0 sent first
   typedef struct packed {
      logic                  is_space;
      logic [CountWidth-1:0] len;
      logic [MaxElems-1:0]   dash;
   } code_type;

   // controller to datapath
   typedef struct packed {
      logic    load;
      logic    emit;
      seg_type seg;
      logic    advance;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;
      logic count_zero;
      logic count_one;
   } status_type;

   function automatic code_type mck_lookup(input logic [CharWidth-1:0] raw);
      logic [CharWidth-1:0] c;
      code_type             r;
      c = raw;
      if (raw >= CharLowerA && raw <= CharLowerZ) begin
         c = raw - CaseOffset;
      end
      r.is_space = 1'b0;
      r.len      = 3'd0;
      r.dash     = 6'b000000;
      case (c)
         CharSpace: r.is_space = 1'b1;                  // space
         8'h41: begin r.len = 3'd2; r.dash = 6'b000010; end  // A .-
         8'h42: begin r.len = 3'd4; r.dash = 6'b000001; end  // B -...
         8'h43: begin r.len = 3'd4; r.dash = 6'b000101; end  // C -.-.
         8'h44: begin r.len = 3'd3; r.dash = 6'b000001; end  // D -..
         8'h45: begin r.len = 3'd1; r.dash = 6'b000000; end  // E .
         8'h46: begin r.len = 3'd4; r.dash = 6'b000100; end  // F ..-.
         8'h47: begin r.len = 3'd3; r.dash = 6'b000011; end  // G --.
         8'h48: begin r.len = 3'd4; r.dash = 6'b000000; end  // H ....
         8'h49: begin r.len = 3'd2; r.dash = 6'b000000; end  // I ..
         8'h4a: begin r.len = 3'd4; r.dash = 6'b001110; end  // J .---
         8'h4b: begin r.len = 3'd4; r.dash = 6'b001010; end  // K .-.-
         8'h4c: begin r.len = 3'd4; r.dash = 6'b000010; end  // L .-..
         8'h4d: begin r.len = 3'd2; r.dash = 6'b000011; end  // M --
         8'h4e: begin r.len = 3'd2; r.dash = 6'b000001; end  // N -.
         8'h4f: begin r.len = 3'd3; r.dash = 6'b000111; end  // O ---
         8'h50: begin r.len = 3'd4; r.dash = 6'b000110; end  // P .--.
         8'h51: begin r.len = 3'd4; r.dash = 6'b001011; end  // Q --.-
         8'h52: begin r.len = 3'd3; r.dash = 6'b000010; end  // R .-.
         8'h53: begin r.len = 3'd3; r.dash = 6'b000000; end  // S ...
         8'h54: begin r.len = 3'd1; r.dash = 6'b000001; end  // T -
         8'h55: begin r.len = 3'd3; r.dash = 6'b000100; end  // U ..-
         8'h56: begin r.len = 3'd4; r.dash = 6'b001000; end  // V ...-
         8'h57: begin r.len = 3'd3; r.dash = 6'b000110; end  // W .--
         8'h58: begin r.len = 3'd4; r.dash = 6'b001001; end  // X -..-
         8'h59: begin r.len = 3'd4; r.dash = 6'b001101; end  // Y -.--
         8'h5a: begin r.len = 3'd4; r.dash = 6'b000011; end  // Z --..
         8'h31: begin r.len = 3'd5; r.dash = 6'b011110; end  // 1 .----
         8'h32: begin r.len = 3'd5; r.dash = 6'b011100; end  // 2 ..---
         8'h33: begin r.len = 3'd5; r.dash = 6'b011000; end  // 3 ...--
         8'h34: begin r.len = 3'd5; r.dash = 6'b010000; end  // 4 ....-
         8'h35: begin r.len = 3'd5; r.dash = 6'b000000; end  // 5 .....
         8'h36: begin r.len = 3'd5; r.dash = 6'b000001; end  // 6 -....
         8'h37: begin r.len = 3'd5; r.dash = 6'b000011; end  // 7 --...
         8'h38: begin r.len = 3'd5; r.dash = 6'b000111; end  // 8 ---..
         8'h39: begin r.len = 3'd5; r.dash = 6'b001111; end  // 9 ----.
         8'h30: begin r.len = 3'd5; r.dash = 6'b011111; end  // 0 -----
         8'h2e: begin r.len = 3'd6; r.dash = 6'b101010; end  // . .-.-.-
         8'h2c: begin r.len = 3'd6; r.dash = 6'b110011; end  // , --..--
         8'h3f: begin r.len = 3'd6; r.dash = 6'b001100; end  // ? ..--..
         8'h21: begin r.len = 3'd6; r.dash = 6'b110101; end  // ! -.-.--
         8'h3a: begin r.len = 3'd6; r.dash = 6'b000111; end  // : ---...
         8'h3b: begin r.len = 3'd6; r.dash = 6'b010101; end  // ; -.-.-.
         8'h28: begin r.len = 3'd5; r.dash = 6'b001101; end  // ( -.--.
         8'h29: begin r.len = 3'd6; r.dash = 6'b101101; end  // ) -.--.-
         8'h22: begin r.len = 3'd6; r.dash = 6'b010010; end  // " .-..-.
         8'h40: begin r.len = 3'd6; r.dash = 6'b010110; end  // @ .--.-.
         8'h26: begin r.len = 3'd5; r.dash = 6'b000010; end  // & .-...
         default: r.len = 3'd0;                          // unknown: end gap only
      endcase
      return r;
   endfunction

endpackage

// ===== design/mck_ctrl.sv =====
// mck_ctrl: sequencer that walks one character's marks and gaps
// uses mck_pkg types; drives the datapath through cmd_type, reads status_type

module mck_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mck_pkg::status_type status,
   output mck_pkg::cmd_type    cmd
);

   mck_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mck_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      cmd.load    = 1'b0;
      cmd.emit    = 1'b0;
      cmd.seg     = mck_pkg::SEG_END_GAP;
      cmd.advance = 1'b0;
      case (state_ff)
         mck_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = mck_pkg::ST_MARK;
            end
         end
         mck_pkg::ST_MARK: begin
            // unknown and space characters carry no elements
            if (status.count_zero) begin
               state_in = mck_pkg::ST_END_GAP;
            end else if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.seg  = mck_pkg::SEG_MARK;
               state_in = mck_pkg::ST_ELEM_GAP;
            end
         end
         mck_pkg::ST_ELEM_GAP: begin
            if (status.slot_free) begin
               cmd.emit    = 1'b1;
               cmd.seg     = mck_pkg::SEG_ELEM_GAP;
               cmd.advance = 1'b1;
               state_in    = status.count_one ? mck_pkg::ST_END_GAP : mck_pkg::ST_MARK;
            end
         end
         mck_pkg::ST_END_GAP: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.seg  = mck_pkg::SEG_END_GAP;
               state_in = mck_pkg::ST_IDLE;
            end
         end
         default: state_in = mck_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== design/mck_dpath.sv =====
// mck_dpath: unit register, code lookup, element shifter and output register
// uses mck_pkg lookup and types; commanded by mck_ctrl

module mck_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mck_pkg::CharWidth-1:0]       req_char_code,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mck_pkg::UnitWidth-1:0]       csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_light_on,
   output logic [mck_pkg::DurWidth-1:0]        rsp_duration_ms,
   output logic                                rsp_last,
   input  mck_pkg::cmd_type                    cmd,
   output mck_pkg::status_type                 status
);

   logic [mck_pkg::UnitWidth-1:0]  unit_ff;
   logic [mck_pkg::MaxElems-1:0]   dash_ff;
   logic [mck_pkg::CountWidth-1:0] count_ff;
   logic                           space_ff;
   logic                           rsp_valid_ff;
   logic                           light_ff, light_in;
   logic                           last_ff, last_in;
   logic [mck_pkg::DurWidth-1:0]   dur_ff, dur_in;
   mck_pkg::code_type              code;
   logic [mck_pkg::DurWidth-1:0]   u1, u3, u6;

   assign csr_ready = 1'b1;

   // unit length register
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= mck_pkg::UnitReset;
      end else if (csr_valid) begin
         unit_ff <= csr_data;
      end
   end

   // element shifter: the current element always sits in bit 0
   assign code = mck_pkg::mck_lookup(req_char_code);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= code.len;
      end else if (cmd.advance) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dash_ff  <= code.dash;
         space_ff <= code.is_space;
      end else if (cmd.advance) begin
         dash_ff <= dash_ff >> 1;
      end
   end

   // unit multiples by shift and add
   assign u1 = {{(mck_pkg::DurWidth-mck_pkg::UnitWidth){1'b0}}, unit_ff};
   assign u3 = (u1 << 1) + u1;
   assign u6 = (u1 << 2) + (u1 << 1);

   // next segment
   always_comb begin
      light_in = 1'b0;
      last_in  = 1'b0;
      dur_in   = u1;
      case (cmd.seg)
         mck_pkg::SEG_MARK: begin
            light_in = 1'b1;
            dur_in   = dash_ff[0] ? u3 : u1;
         end
         mck_pkg::SEG_ELEM_GAP: dur_in = u1;
         mck_pkg::SEG_END_GAP: begin
            last_in = 1'b1;
            dur_in  = space_ff ? u6 : u1;
         end
         default: dur_in = u1;
      endcase
   end

   // output register
   assign status.slot_free  = !rsp_valid_ff || !rsp_stall;
   assign status.count_zero = (count_ff == '0);
   assign status.count_one  = (count_ff == {{(mck_pkg::CountWidth-1){1'b0}}, 1'b1});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         light_ff <= light_in;
         last_ff  <= last_in;
         dur_ff   <= dur_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_light_on    = light_ff;
   assign rsp_duration_ms = dur_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== design/morse_char_keyer.sv =====
// morse_char_keyer: top level joining the sequencer and the datapath
// depends on mck_pkg, mck_ctrl and mck_dpath

// Takes one ASCII character per item (lower case folded to upper case) and
// returns its lamp segments as a run of result items: a mark of one or three
// units and a one-unit gap per element, then a one-unit closing gap flagged
// last; a space yields one six-unit gap and an unknown code only the closing
// gap. Durations are units times the unit length written on the csr port
// (reset 250). One segment enters the output register per cycle when the
// result side does not stall, so a character with elements yields
// 2 * elements + 1 segments, up to 13, after it is accepted, paced by the
// sequencer's walk through the element shifter; a space or an unknown code
// first passes the mark state, finding that it has no elements, before its
// closing gap. A stall on the result side holds the sequencer back.
// The input stalls until the last segment of the character has been issued.

module morse_char_keyer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mck_pkg::CharWidth-1:0] req_char_code,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mck_pkg::UnitWidth-1:0] csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_light_on,
   output logic [mck_pkg::DurWidth-1:0]  rsp_duration_ms,
   output logic                          rsp_last
);

   mck_pkg::cmd_type    cmd;
   mck_pkg::status_type status;

   // sequencer
   mck_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   mck_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_char_code   (req_char_code),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_light_on    (rsp_light_on),
      .rsp_duration_ms (rsp_duration_ms),
      .rsp_last        (rsp_last),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// ===== test/morse_char_keyer_test.sv =====
// morse_char_keyer_test: self-checking bench for the morse keyer, with its own
// segment predictor, random stalls on both channels and unit-length sweeps
// depends on mck_pkg and morse_char_keyer

module morse_char_keyer_test;

   localparam int PhaseCount     = 6;
   localparam int RandomPerPhase = 35;
   localparam int LongHold       = 300;
   localparam int DrainLimit     = 4000;
   localparam int SettleCycles   = 6;
   localparam int ResetUnitMs    = 250;
   localparam int SpaceUnits     = 6;
   localparam int DashUnits      = 3;

   typedef struct packed {
      logic                         light_on;
      logic [mck_pkg::DurWidth-1:0] duration_ms;
      logic                         last;
   } lamp_seg_type;

   // one offered character; fixed marks a row whose single segment is typed in
   typedef struct packed {
      logic [mck_pkg::CharWidth-1:0] code;
      logic                          fixed;
      lamp_seg_type                  seg;
   } char_row_type;

   localparam lamp_seg_type NoSeg = '0;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [mck_pkg::CharWidth-1:0] req_char_code;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [mck_pkg::UnitWidth-1:0] csr_data;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic                          rsp_light_on;
   logic [mck_pkg::DurWidth-1:0]  rsp_duration_ms;
   logic                          rsp_last;

   lamp_seg_type                  due_segments [$];
   char_row_type                  offered_chars [$];
   logic [mck_pkg::UnitWidth-1:0] unit_ms;
   int                            error_count;
   bit                            idling_on;
   bit                            long_hold_req;
   string                         key_chars;

   // directed rows: typed rows assume the reset unit length of 250 ms
   char_row_type directed_rows [24] = '{
      '{"E", 1'b0, NoSeg},
      '{"T", 1'b0, NoSeg},
      '{"M", 1'b0, NoSeg},
      '{".", 1'b0, NoSeg},
      '{",", 1'b0, NoSeg},
      '{"5", 1'b0, NoSeg},
      '{"0", 1'b0, NoSeg},
      '{"a", 1'b0, NoSeg},
      '{"z", 1'b0, NoSeg},
      '{"A", 1'b0, NoSeg},
      '{"Z", 1'b0, NoSeg},
      '{" ", 1'b1, '{1'b0, 15'd1500, 1'b1}},
      '{8'h00, 1'b1, '{1'b0, 15'd250, 1'b1}},
      '{8'hff, 1'b1, '{1'b0, 15'd250, 1'b1}},
      '{8'h80, 1'b1, '{1'b0, 15'd250, 1'b1}},
      '{8'h7f, 1'b1, '{1'b0, 15'd250, 1'b1}},
      '{8'h60, 1'b1, '{1'b0, 15'd250, 1'b1}},
      '{8'h7b, 1'b1, '{1'b0, 15'd250, 1'b1}},
      '{"@", 1'b0, NoSeg},
      '{"&", 1'b0, NoSeg},
      '{"(", 1'b0, NoSeg},
      '{")", 1'b0, NoSeg},
      '{"\"", 1'b0, NoSeg},
      '{"?", 1'b0, NoSeg}
   };

   morse_char_keyer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_light_on    (rsp_light_on),
      .rsp_duration_ms (rsp_duration_ms),
      .rsp_last        (rsp_last)
   );

   // dots and dashes sent for an upper-case character, empty when unknown
   function automatic string morse_marks(input logic [mck_pkg::CharWidth-1:0] c);
      case (c)
         "A": return ".-";     "B": return "-...";   "C": return "-.-.";
         "D": return "-..";    "E": return ".";      "F": return "..-.";
         "G": return "--.";    "H": return "....";   "I": return "..";
         "J": return ".---";   "K": return ".-.-";   "L": return ".-..";
         "M": return "--";     "N": return "-.";     "O": return "---";
         "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
         "S": return "...";    "T": return "-";      "U": return "..-";
         "V": return "...-";   "W": return ".--";    "X": return "-..-";
         "Y": return "-.--";   "Z": return "--..";
         "1": return ".----";  "2": return "..---";  "3": return "...--";
         "4": return "....-";  "5": return ".....";  "6": return "-....";
         "7": return "--...";  "8": return "---..";  "9": return "----.";
         "0": return "-----";
         ".": return ".-.-.-"; ",": return "--..--"; "?": return "..--..";
         "!": return "-.-.--"; ":": return "---..."; ";": return "-.-.-.";
         "(": return "-.--.";  ")": return "-.--.-"; "\"": return ".-..-.";
         "@": return ".--.-."; "&": return ".-...";
         default: return "";
      endcase
   endfunction

   function automatic lamp_seg_type make_seg(input logic lit, input int units,
                                             input logic fin);
      lamp_seg_type s;
      s.light_on    = lit;
      s.duration_ms = mck_pkg::DurWidth'(units * int'(unit_ms));
      s.last        = fin;
      return s;
   endfunction

   // queue the lamp segments that one character should produce
   task automatic key_segments(input logic [mck_pkg::CharWidth-1:0] raw);
      logic [mck_pkg::CharWidth-1:0] c;
      string                         marks;
      c = raw;
      if (c >= "a" && c <= "z") begin
         c = c - 8'h20;
      end
      if (c == " ") begin
         due_segments.push_back(make_seg(1'b0, SpaceUnits, 1'b1));
      end else begin
         marks = morse_marks(c);
         for (int i = 0; i < marks.len(); i++) begin
            due_segments.push_back(make_seg(1'b1, (marks[i] == "-") ? DashUnits : 1, 1'b0));
            due_segments.push_back(make_seg(1'b0, 1, 1'b0));
         end
         due_segments.push_back(make_seg(1'b0, 1, 1'b1));
      end
   endtask

   function automatic logic [mck_pkg::CharWidth-1:0] random_char();
      int                            pick;
      logic [mck_pkg::CharWidth-1:0] c;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         c = key_chars[$urandom_range(0, key_chars.len() - 1)];
         if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) begin
            c = c + 8'h20;
         end
      end else if (pick == 7) begin
         c = " ";
      end else begin
         c = mck_pkg::CharWidth'($urandom_range(0, 255));
      end
      return c;
   endfunction

   // hold the character until the keyer takes it
   task automatic offer_char(input char_row_type row);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      offered_chars.push_back(row);
      req_valid     <= 1'b1;
      req_char_code <= row.code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_unit(input logic [mck_pkg::UnitWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      unit_ms = value;
   endtask

   // let every queued segment come out, then a few quiet cycles
   task automatic drain_segments();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_segments.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      if (due_segments.size() != 0) begin
         $display("%0t: %0d segments never arrived", $time, due_segments.size());
         error_count++;
         due_segments.delete();
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

   // result side stall: random bursts, plus one long hold-off on request
   initial begin : result_stall
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LongHold) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // predict on accepted characters, check accepted segments
   always @(posedge clock) begin : segment_check
      char_row_type row;
      lamp_seg_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            row = (offered_chars.size() != 0) ? offered_chars.pop_front() : '0;
            if (row.fixed) begin
               due_segments.push_back(row.seg);
            end else begin
               key_segments(req_char_code);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_segments.size() == 0) begin
               $display("%0t: unexpected segment light %0b dur %0d last %0b", $time,
                        rsp_light_on, rsp_duration_ms, rsp_last);
               error_count++;
            end else begin
               want = due_segments.pop_front();
               if (rsp_light_on !== want.light_on) begin
                  $display("%0t: light_on expected %0b actual %0b", $time,
                           want.light_on, rsp_light_on);
                  error_count++;
               end
               if (rsp_duration_ms !== want.duration_ms) begin
                  $display("%0t: duration_ms expected %0d actual %0d", $time,
                           want.duration_ms, rsp_duration_ms);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0b actual %0b", $time,
                           want.last, rsp_last);
                  error_count++;
               end
            end
         end
      end
   end

   // stimulus: directed table at reset unit length, then random phases
   initial begin : stimulus
      logic [mck_pkg::UnitWidth-1:0] phase_units [PhaseCount];
      char_row_type                  row;
      error_count   = 0;
      idling_on     = 1'b1;
      long_hold_req = 1'b0;
      unit_ms       = mck_pkg::UnitWidth'(ResetUnitMs);
      key_chars     = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?!:;()\"@&";
      phase_units   = '{12'd1, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0};
      for (int p = 3; p < PhaseCount; p++) begin
         phase_units[p] = mck_pkg::UnitWidth'($urandom_range(2, 4094));
      end
      req_valid     <= 1'b0;
      req_char_code <= '0;
      csr_valid     <= 1'b0;
      csr_data      <= '0;
      reset         <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         offer_char(directed_rows[i]);
      end
      drain_segments();

      for (int p = 0; p < PhaseCount; p++) begin
         // final phase runs with no idling on either side
         if (p == PhaseCount - 1) begin
            idling_on = 1'b0;
         end
         write_unit(phase_units[p]);
         // hold results back so the keyer backs up into its input
         if (p == 0) begin
            long_hold_req = 1'b1;
         end
         repeat (RandomPerPhase) begin
            row.code  = random_char();
            row.fixed = 1'b0;
            row.seg   = NoSeg;
            offer_char(row);
         end
         drain_segments();
      end

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/mck_pkg.sv
design/mck_ctrl.sv
design/mck_dpath.sv
design/morse_char_keyer.sv
test/morse_char_keyer_test.sv
